@@ rtl/core/vaos_pkg.sv @@
package vaos_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = 4;
    localparam int TIME_W = 64;
    localparam int VOICE_W = 5;

    typedef enum logic [1:0] {
        OP_ACQUIRE     = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_RELEASE_ALL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
    } stamp_req_t;

endpackage

@@ rtl/core/voice_allocator_oldest_steal_top.sv @@
// Channel   Direction  Contents
// s_        in         tuser: operation; tdata: now_ms, slot_to_release
// m_        out        tdata: granted_slot, was_stolen
// cfg_      in         wdata: voices_in_use
//
// An acquire scans one slot per cycle through the shared stamp compare unit.
// With n searched slots (voices_in_use held to 1..16) an acquire scans until a free slot or the
// n-th slot, steals via ST_DRAIN if all n are busy, and loads the result register in ST_FINISH;
// releases go straight to ST_FINISH. A stalled result holds the next one back.
// A new request is taken in the cycle after the result register is loaded,
// even while that result still waits on m_tready.
// Reset clears all busy flags, sets voices_in_use to 1 and empties the output.
module voice_allocator_oldest_steal_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [1:0]                    s_tuser,   // operation
    input  logic [71:0]                   s_tdata,   // now_ms, slot_to_release, zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // granted_slot, was_stolen, zero fill
    input  logic                          cfg_we,
    input  logic [vaos_pkg::VOICE_W-1:0]  cfg_wdata
);
    import vaos_pkg::*;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [SLOT_W-1:0] rel_reg, rel_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] grant_reg, grant_next;
    logic              stolen_reg, stolen_next;
    logic [SLOTS-1:0]  busy_reg, busy_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;
    logic [VOICE_W-1:0] voices_reg;
    logic [SLOT_W-1:0] last_idx;
    logic [SLOT_W-1:0] oldest_idx_next;
    stamp_req_t        req;

    vaos_stamp_unit u_stamp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req             (req),
        .wr_data         (now_reg),
        .oldest_idx_next (oldest_idx_next)
    );

    always_comb begin
        if (voices_reg == '0) begin
            last_idx = '0;
        end else if (voices_reg > VOICE_W'(SLOTS)) begin
            last_idx = SLOT_W'(SLOTS - 1);
        end else begin
            last_idx = SLOT_W'(voices_reg - VOICE_W'(1));
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        now_next      = now_reg;
        rel_next      = rel_reg;
        idx_next      = idx_reg;
        grant_next    = grant_reg;
        stolen_next   = stolen_reg;
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        req.rd_en     = 1'b0;
        req.rd_addr   = idx_reg;
        req.wr_en     = 1'b0;
        req.wr_addr   = grant_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = op_t'(s_tuser);
                    now_next    = s_tdata[TIME_W-1:0];
                    rel_next    = s_tdata[TIME_W+SLOT_W-1:TIME_W];
                    idx_next    = '0;
                    grant_next  = '0;
                    stolen_next = 1'b0;
                    if (op_t'(s_tuser) == OP_ACQUIRE) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (!busy_reg[idx_reg]) begin
                    grant_next  = idx_reg;
                    stolen_next = 1'b0;
                    state_next  = ST_FINISH;
                end else begin
                    req.rd_en = 1'b1;
                    if (idx_reg == last_idx) begin
                        state_next = ST_DRAIN;
                    end else begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                grant_next  = oldest_idx_next;
                stolen_next = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, stolen_reg, grant_reg};
                    state_next    = ST_IDLE;
                    unique case (op_reg)
                        OP_ACQUIRE: begin
                            busy_next[grant_reg] = 1'b1;
                            req.wr_en            = 1'b1;
                        end
                        OP_RELEASE: begin
                            busy_next[rel_reg] = 1'b0;
                        end
                        OP_RELEASE_ALL: begin
                            busy_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            busy_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            voices_reg   <= VOICE_W'(1);
        end else begin
            state_reg    <= state_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                voices_reg <= cfg_wdata;
            end
        end
        op_reg      <= op_next;
        now_reg     <= now_next;
        rel_reg     <= rel_next;
        idx_reg     <= idx_next;
        grant_reg   <= grant_next;
        stolen_reg  <= stolen_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

@@ rtl/core/vaos_stamp_unit.sv @@
module vaos_stamp_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  vaos_pkg::stamp_req_t                req,
    input  logic [vaos_pkg::TIME_W-1:0]         wr_data,
    output logic [vaos_pkg::SLOT_W-1:0]         oldest_idx_next
);
    import vaos_pkg::*;

    logic [TIME_W-1:0] stamp_mem [SLOTS];
    logic [TIME_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0] cmp_idx_reg;
    logic              cmp_valid_reg;
    logic [TIME_W-1:0] oldest_time_reg;
    logic [TIME_W-1:0] oldest_time_next;
    logic [SLOT_W-1:0] oldest_idx_reg;
    logic              cmp_take;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            stamp_mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= stamp_mem[req.rd_addr];
            cmp_idx_reg <= req.rd_addr;
        end
    end

    // The first slot of a scan always seeds the running minimum.
    assign cmp_take = cmp_valid_reg &&
                      ((cmp_idx_reg == '0) || (rd_data_reg < oldest_time_reg));

    always_comb begin
        oldest_idx_next  = oldest_idx_reg;
        oldest_time_next = oldest_time_reg;
        if (cmp_take) begin
            oldest_idx_next  = cmp_idx_reg;
            oldest_time_next = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= req.rd_en;
        end
        oldest_idx_reg  <= oldest_idx_next;
        oldest_time_reg <= oldest_time_next;
    end

endmodule

@@ rtl/core/vaos_checker.sv @@
module vaos_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // A taken request leaves the block busy in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one is in progress");

    // A new result appears only as the block finishes a request.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without request in progress");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind voice_allocator_oldest_steal_top vaos_checker u_vaos_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
